FILE: design/ftlb_pkg.sv
`default_nettype none

package ftlb_pkg;

  // Geometry of the buffer
  localparam int ENTRIES     = 16;
  localparam int PAGE_SHIFT  = 12;
  localparam int ADDR_BITS   = 32;
  localparam int AGE_BITS    = 16;
  localparam int DATA_BITS   = 32;
  localparam int OPC_BITS    = 2;
  localparam int VPN_BITS    = ADDR_BITS - PAGE_SHIFT;
  localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Operation codes; the remaining code is a no-op
  typedef enum logic [OPC_BITS-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_INVAL  = 2'd2
  } ftlb_op_t;

  typedef logic [VPN_BITS-1:0]    ftlb_page_t;
  typedef logic [IDX_BITS-1:0]    ftlb_idx_t;
  typedef logic [ENTRIES-1:0]     ftlb_mask_t;
  typedef logic [AGE_BITS-1:0]    ftlb_age_t;
  typedef logic [PAGE_SHIFT-1:0]  ftlb_off_t;
  // Row i, bit j set: entry i is strictly older than entry j
  typedef ftlb_mask_t [ENTRIES-1:0] ftlb_omat_t;

  // Operation handed to the entry array
  typedef struct packed {
    logic                exec;
    logic [OPC_BITS-1:0] opcode;
    ftlb_page_t          vpn;
    ftlb_page_t          ppn;
  } ftlb_cmd_t;

  // Lookup answer from the entry array
  typedef struct packed {
    logic       hit;
    ftlb_page_t ppn;
  } ftlb_look_t;

  // Encode a one-hot entry mask into its index
  function automatic ftlb_idx_t onehot_to_idx(input ftlb_mask_t oh);
    ftlb_idx_t idx;
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (oh[i]) begin
        idx = idx | ftlb_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: design/ftlb_ifs.sv
`default_nettype none

// Request channel: one operation per transfer
interface ftlb_req_if import ftlb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OPC_BITS-1:0]  opcode;
  logic [DATA_BITS-1:0] virt_addr;
  logic [DATA_BITS-1:0] phys_addr;

  modport source (output valid, output opcode, output virt_addr, output phys_addr,
                  input ready);
  modport sink   (input valid, input opcode, input virt_addr, input phys_addr,
                  output ready);
endinterface

// Response channel: one result per request
interface ftlb_rsp_if import ftlb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DATA_BITS-1:0] translated_addr;

  modport source (output valid, output hit, output translated_addr, input ready);
  modport sink   (input valid, input hit, input translated_addr, output ready);
endinterface

`default_nettype wire

FILE: design/ftlb_victim.sv
`default_nettype none

module ftlb_victim import ftlb_pkg::*; (
  input  ftlb_mask_t valid_i,
  input  ftlb_omat_t older_i,
  output ftlb_idx_t  slot_o
);

  ftlb_mask_t free;
  ftlb_mask_t blocked;
  ftlb_mask_t oldest;
  ftlb_mask_t pool;
  ftlb_mask_t first;

  // Pick the lowest free entry, else the lowest entry that nobody is older than
  always_comb begin
    free = ~valid_i;
    for (int i = 0; i < ENTRIES; i++) begin
      blocked[i] = 1'b0;
      for (int j = 0; j < ENTRIES; j++) begin
        blocked[i] = blocked[i] | (valid_i[j] & older_i[j][i]);
      end
    end
    oldest = valid_i & ~blocked;
    pool   = (free != '0) ? free : oldest;
    first  = pool & (~pool + ftlb_mask_t'(1));
    slot_o = onehot_to_idx(first);
  end

endmodule

`default_nettype wire

FILE: design/ftlb_array.sv
`default_nettype none

module ftlb_array import ftlb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ftlb_cmd_t  cmd_i,
  output ftlb_look_t look_o
);

  ftlb_mask_t valid_r, valid_nxt;
  ftlb_page_t vpage_r [ENTRIES];
  ftlb_page_t ppage_r [ENTRIES];
  ftlb_age_t  age_r   [ENTRIES];
  ftlb_age_t  age_nxt [ENTRIES];
  ftlb_omat_t older_r, older_nxt;

  ftlb_mask_t match;
  ftlb_mask_t first;
  ftlb_mask_t add_mask;
  ftlb_mask_t sat_nxt;
  ftlb_idx_t  slot;
  ftlb_idx_t  hit_idx;
  ftlb_age_t  age_base;
  logic       do_add;
  logic       do_inv;
  logic       do_age;

  // Replacement slot follows from the current entry state
  ftlb_victim u_victim (
    .valid_i (valid_r),
    .older_i (older_r),
    .slot_o  (slot)
  );

  // Compare the page against every entry, lowest match wins
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] & (vpage_r[i] == cmd_i.vpn);
    end
    first      = match & (~match + ftlb_mask_t'(1));
    hit_idx    = onehot_to_idx(first);
    look_o.hit = (match != '0);
    look_o.ppn = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      look_o.ppn = look_o.ppn | ({VPN_BITS{first[i]}} & ppage_r[i]);
    end
  end

  // Next valid bits, ages and age order
  always_comb begin
    do_add   = cmd_i.exec & (cmd_i.opcode == OP_ADD);
    do_inv   = cmd_i.exec & (cmd_i.opcode == OP_INVAL);
    do_age   = do_add | do_inv;
    add_mask = do_add ? (ftlb_mask_t'(1) << slot) : '0;

    valid_nxt = valid_r | add_mask;
    if (do_inv) begin
      valid_nxt = valid_r & ~match;
    end

    age_base = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      age_base   = add_mask[i] ? '0 : age_r[i];
      age_nxt[i] = age_base;
      if (do_age && valid_nxt[i] && !(&age_base)) begin
        age_nxt[i] = age_base + ftlb_age_t'(1);
      end
      sat_nxt[i] = &age_nxt[i];
    end

    // A new entry is younger than all others; saturated ages tie
    older_nxt = older_r;
    if (do_age) begin
      for (int i = 0; i < ENTRIES; i++) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (add_mask[i]) begin
            older_nxt[i][j] = 1'b0;
          end else if (add_mask[j]) begin
            older_nxt[i][j] = valid_nxt[i];
          end else begin
            older_nxt[i][j] = older_r[i][j] & ~sat_nxt[j];
          end
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      older_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      older_r <= older_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  // Write the mapping into the chosen slot
  always_ff @(posedge clk) begin
    if (do_add) begin
      vpage_r[slot] <= cmd_i.vpn;
      ppage_r[slot] <= cmd_i.ppn;
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r != {ENTRIES{1'b1}}) |-> !valid_r[slot])
    else $error("replacement slot is valid while a free entry exists");

  a_add_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_add |=> valid_r[$past(slot)])
    else $error("added entry is not valid");

  a_inv_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (do_inv && look_o.hit) |=> !valid_r[$past(hit_idx)])
    else $error("matching entry survived invalidate");

endmodule

`default_nettype wire

FILE: design/fully_associative_tlb.sv
// A request is held in the request register, then its response in the response register.
// Throughput: one request per cycle while responses are taken; the entry array updates as
// a request enters the response register, so the following request already sees its effect.
// Reset (synchronous, rst_n low): all entries invalid, ages and age order cleared,
// replacement slot 0, both pipeline registers empty.
`default_nettype none

module fully_associative_tlb import ftlb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ftlb_req_if.sink   in_req,
  ftlb_rsp_if.source out_rsp
);

  logic                 req_vld_r;
  logic [OPC_BITS-1:0]  req_op_r;
  ftlb_page_t           req_vpn_r;
  ftlb_page_t           req_ppn_r;
  ftlb_off_t            req_off_r;
  logic                 out_vld_r;
  logic                 out_hit_r, out_hit_nxt;
  logic [DATA_BITS-1:0] out_addr_r, out_addr_nxt;

  logic       adv;
  logic       in_rdy;
  ftlb_cmd_t  cmd;
  ftlb_look_t look;

  // Advance when the response register is free or being drained
  assign adv          = ~out_vld_r | out_rsp.ready;
  assign in_rdy       = ~req_vld_r | adv;
  assign in_req.ready = in_rdy;

  assign cmd.exec   = req_vld_r & adv;
  assign cmd.opcode = req_op_r;
  assign cmd.vpn    = req_vpn_r;
  assign cmd.ppn    = req_ppn_r;

  ftlb_array u_array (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (cmd),
    .look_o (look)
  );

  // Form the response: translation only for a lookup hit
  always_comb begin
    out_hit_nxt  = look.hit & (req_op_r == OP_LOOKUP);
    out_addr_nxt = out_hit_nxt ? DATA_BITS'({look.ppn, req_off_r}) : '0;
  end

  // Hold pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        req_vld_r <= in_req.valid;
      end
      if (adv) begin
        out_vld_r <= req_vld_r;
      end
    end
  end

  // Capture the request and the response
  always_ff @(posedge clk) begin
    if (in_req.valid && in_rdy) begin
      req_op_r  <= in_req.opcode;
      req_vpn_r <= in_req.virt_addr[ADDR_BITS-1:PAGE_SHIFT];
      req_ppn_r <= in_req.phys_addr[ADDR_BITS-1:PAGE_SHIFT];
      req_off_r <= in_req.virt_addr[PAGE_SHIFT-1:0];
    end
    if (adv && req_vld_r) begin
      out_hit_r  <= out_hit_nxt;
      out_addr_r <= out_addr_nxt;
    end
  end

  assign out_rsp.valid           = out_vld_r;
  assign out_rsp.hit             = out_hit_r;
  assign out_rsp.translated_addr = out_addr_r;

endmodule

`default_nettype wire
